[hw/rtl/lpc_synthesis_deemphasis_postfilter_defines.svh]
// Assertion macros shared by the postfilter RTL.
`ifndef LPC_SYNTHESIS_DEEMPHASIS_POSTFILTER_DEFINES_SVH
`define LPC_SYNTHESIS_DEEMPHASIS_POSTFILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSDP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lsdp_pkg.sv]
// Types, constants and helpers shared by the postfilter modules.
`default_nettype none
package lsdp_pkg;

    localparam int OPC_W   = 2;
    localparam int IDX_W   = 4;
    localparam int VAL_W   = 16;
    localparam int SMP_W   = 24;
    localparam int DCOEF_W = 15;
    localparam int PROD_W  = SMP_W + VAL_W;
    localparam int ACC_W   = 46;

    localparam logic [OPC_W-1:0] OP_LOAD_COEF = 2'd0;
    localparam logic [OPC_W-1:0] OP_LOAD_GAIN = 2'd1;
    localparam logic [OPC_W-1:0] OP_SAMPLE    = 2'd2;

    localparam logic [VAL_W-1:0]   GAIN_RESET  = 16'd1024;
    localparam logic [DCOEF_W-1:0] DCOEF_RESET = 15'd27853;

    localparam logic signed [ACC_W-1:0] SAT_MAX = 46'sd8388607;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -46'sd8388608;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MAC    = 4'b0010,
        S_ROUND  = 4'b0100,
        S_DEEMPH = 4'b1000
    } t_state;

    typedef struct packed {
        logic init;
        logic mul_en;
        logic acc_en;
    } t_mac_ctl;

    typedef struct packed {
        logic                    clip;
        logic signed [SMP_W-1:0] val;
    } t_sat;

    function automatic t_sat sat24(input logic signed [ACC_W-1:0] v);
        t_sat r;
        r.clip = 1'b0;
        r.val  = v[SMP_W-1:0];
        if (v > SAT_MAX) begin
            r.clip = 1'b1;
            r.val  = SAT_MAX[SMP_W-1:0];
        end else if (v < SAT_MIN) begin
            r.clip = 1'b1;
            r.val  = SAT_MIN[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/lpc_synthesis_deemphasis_postfilter.sv]
// LPC all-pole synthesis filter with gain scaling and de-emphasis, top level.
//
// Input stream (s side): tuser carries the opcode, tdata carries coef_index
// and value. Load-coefficient and load-gain transfers produce nothing. A sample
// transfer runs the sequencer: one read of the coefficient and history
// memories per tap, a registered multiply and a subtract per tap, then
// rounding, the history write and de-emphasis.
// Output stream (m side): tdata carries sample_out, tuser the clip flag.
// A sample transfer passes through the tap walk, rounding and de-emphasis to
// the output register. A sample holds o_s_tready low until the sequencer is
// back in idle, so the next sample is not taken before the last one leaves
// de-emphasis; the memory read ports walking the taps set the pace. The output
// register lets the next item in while a result waits; if the receiver stalls
// with a result still held, the next sample parks in the de-emphasis step
// until the output register frees up. The de-emphasis coefficient port writes
// on any cycle with i_cfg_wr_en high. Synchronous reset clears the history and
// coefficients through valid bits, restores gain to 1.0 and the
// de-emphasis coefficient to 0.85; no clearing pass is needed.
`default_nettype none
`include "lpc_synthesis_deemphasis_postfilter_defines.svh"
module lpc_synthesis_deemphasis_postfilter
    import lsdp_pkg::*;
#(
    parameter int ORDER = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input stream
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [23:0]        i_s_tdata,     // [3:0] coef_index, [19:4] value
    input  wire logic [OPC_W-1:0]   i_s_tuser,     // [1:0] opcode
    // output stream
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [SMP_W-1:0]        o_m_tdata,     // [23:0] sample_out
    output logic                    o_m_tuser,     // [0] saturated
    // configuration
    input  wire logic               i_cfg_wr_en,
    input  wire logic [DCOEF_W-1:0] i_cfg_wr_data
);

    localparam int AW = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int CW = $clog2(ORDER + 2);
    localparam logic [AW-1:0] LAST_SLOT = AW'(ORDER - 1);
    localparam logic [CW-1:0] CNT_ORDER = CW'(ORDER);
    localparam logic [CW-1:0] CNT_LAST  = CW'(ORDER + 1);

    // unpacked input fields
    logic [OPC_W-1:0]        w_opcode;
    logic [IDX_W-1:0]        w_idx;
    logic signed [VAL_W-1:0] w_value;
    logic [31:0]             w_idx32;
    logic                    w_s_xfer;
    logic                    w_out_free;

    assign w_opcode = i_s_tuser;
    assign w_idx    = i_s_tdata[IDX_W-1:0];
    assign w_value  = i_s_tdata[IDX_W +: VAL_W];
    assign w_idx32  = 32'(w_idx);

    // control and payload registers
    t_state                   r_state, n_state;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [AW-1:0]            r_head, r_rptr;
    logic [VAL_W-1:0]         r_gain;
    logic [DCOEF_W-1:0]       r_dcoef;
    logic signed [31:0]       r_gprod;
    logic signed [SMP_W-1:0]  r_s;
    logic                     r_clip;
    logic signed [PROD_W-1:0] r_dprod;
    logic signed [SMP_W-1:0]  r_dmem;
    logic                     r_out_vld;
    logic [SMP_W-1:0]         r_out_data;
    logic                     r_out_sat;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_xfer   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_vld || i_m_tready;

    // pointer arithmetic around the circular history
    logic [AW-1:0] w_head_inc, w_rptr_dec;
    assign w_head_inc = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
    assign w_rptr_dec = (r_rptr == '0) ? LAST_SLOT : r_rptr - AW'(1);

    // coefficient store: write on load transfers in range, read tap by tap
    logic                    w_coef_we;
    logic [VAL_W-1:0]        w_coef_q;
    assign w_coef_we = w_s_xfer && (w_opcode == OP_LOAD_COEF) && (w_idx32 < ORDER);

    lsdp_vram #(.DEPTH(ORDER), .W(VAL_W)) u_coef_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_coef_we),
        .i_waddr (w_idx32[AW-1:0]),
        .i_wdata (w_value),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (w_coef_q)
    );

    // synthesis history: newest at r_head, walk backward during the taps
    logic                    w_hist_we;
    logic [SMP_W-1:0]        w_hist_q;
    t_sat                    w_syn;
    assign w_hist_we = (r_state == S_ROUND);

    lsdp_vram #(.DEPTH(ORDER), .W(SMP_W)) u_hist_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_hist_we),
        .i_waddr (w_head_inc),
        .i_wdata (w_syn.val),
        .i_raddr (r_rptr),
        .o_rdata (w_hist_q)
    );

    // gain-scaled excitation, rounded to Q8.15 and moved to 27 fraction bits
    logic signed [32:0]      w_gsum;
    logic signed [ACC_W-1:0] w_init;
    assign w_gsum = 33'(r_gprod) + 33'sd512;
    assign w_init = ACC_W'(w_gsum >>> 10) <<< 12;

    t_mac_ctl                w_mac_ctl;
    logic signed [ACC_W-1:0] w_acc;
    always_comb begin
        w_mac_ctl.init   = (r_state == S_MAC) && (r_cnt == '0);
        w_mac_ctl.mul_en = (r_state == S_MAC) && (r_cnt != '0) && (r_cnt <= CNT_ORDER);
        w_mac_ctl.acc_en = (r_state == S_MAC) && (r_cnt > CW'(1));
    end

    lsdp_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .i_init (w_init),
        .i_hist (w_hist_q),
        .i_coef (w_coef_q),
        .o_acc  (w_acc)
    );

    // round and clip the synthesis sum
    logic signed [ACC_W-1:0] w_rsum;
    assign w_rsum = w_acc + ACC_W'(2048);
    assign w_syn  = sat24(w_rsum >>> 12);

    // de-emphasis: y = s + round(coef * previous y)
    logic signed [PROD_W-1:0] w_dsum;
    logic signed [ACC_W-1:0]  w_y;
    t_sat                     w_de;
    assign w_dsum = r_dprod + PROD_W'(16384);
    assign w_y    = ACC_W'(r_s) + ACC_W'(w_dsum >>> 15);
    assign w_de   = sat24(w_y);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_s_xfer && (w_opcode == OP_SAMPLE)) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_state = S_DEEMPH;
            end
            S_DEEMPH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_head    <= '0;
            r_rptr    <= '0;
            r_gain    <= GAIN_RESET;
            r_dcoef   <= DCOEF_RESET;
            r_dmem    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_wr_en) begin
                r_dcoef <= i_cfg_wr_data;
            end
            if (w_s_xfer && (w_opcode == OP_LOAD_GAIN)) begin
                // clamp a negative gain to zero
                r_gain <= w_value[VAL_W-1] ? '0 : w_value;
            end
            if (r_state == S_IDLE) begin
                r_rptr <= r_head;
            end else if (r_state == S_MAC) begin
                r_rptr <= w_rptr_dec;
            end
            if (r_state == S_ROUND) begin
                r_head <= w_head_inc;
            end
            if ((r_state == S_DEEMPH) && w_out_free) begin
                r_out_vld <= 1'b1;
                r_dmem    <= w_de.val;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_gprod <= w_value * $signed(r_gain);
        end
        if (r_state == S_ROUND) begin
            r_s     <= w_syn.val;
            r_clip  <= w_syn.clip;
            r_dprod <= $signed({1'b0, r_dcoef}) * r_dmem;
        end
        if ((r_state == S_DEEMPH) && w_out_free) begin
            r_out_data <= w_de.val;
            r_out_sat  <= r_clip || w_de.clip;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_sat;

    `LSDP_ASSERT_IMP(a_out_from_deemph, $rose(o_m_tvalid), $past(r_state) == S_DEEMPH, "result appeared outside de-emphasis step")
    `LSDP_ASSERT_NEXT(a_sample_starts_mac, w_s_xfer && (w_opcode == OP_SAMPLE), (r_state == S_MAC) && (r_cnt == '0), "sample transfer did not start the tap walk")
    `LSDP_ASSERT_IMP(a_cnt_bound, r_state == S_MAC, r_cnt <= CNT_LAST, "tap counter ran past the last tap")

endmodule
`default_nettype wire

[hw/rtl/lsdp_vram.sv]
// Synchronous memory with per-entry valid bits; unwritten entries read as zero.
`default_nettype none
module lsdp_vram
    import lsdp_pkg::*;
#(
    parameter  int DEPTH = 16,
    parameter  int W     = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0]     r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [W-1:0]     r_q;
    logic             r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_q_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_q_vld ? r_q : '0;

endmodule
`default_nettype wire

[hw/rtl/lsdp_mac.sv]
// Multiply-accumulate unit: registered product, then subtract into the accumulator.
`default_nettype none
module lsdp_mac
    import lsdp_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire t_mac_ctl                i_ctl,
    input  wire logic signed [ACC_W-1:0] i_init,
    input  wire logic signed [SMP_W-1:0] i_hist,
    input  wire logic signed [VAL_W-1:0] i_coef,
    output logic signed      [ACC_W-1:0] o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_hist * i_coef;
        end
        if (i_ctl.init) begin
            r_acc <= i_init;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc - ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire
